// ===== rtl/core/vwe_pkg.sv =====
package vwe_pkg;

    // Table sizes and coordinate precision
    localparam int MAX_UNIQUE   = 256;
    localparam int MAX_VERTICES = 1024;
    localparam int COORD_BITS   = 24;

    // Fixed port widths
    localparam int POS_W  = 24;
    localparam int FACE_W = 10;
    localparam int WIDX_W = 10;
    localparam int EPS_W  = 50;

    localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(1);

    // Derived index and counter widths
    localparam int UIDX_W = $clog2(MAX_UNIQUE);
    localparam int UCNT_W = $clog2(MAX_UNIQUE + 1);
    localparam int VIDX_W = $clog2(MAX_VERTICES);
    localparam int VCNT_W = $clog2(MAX_VERTICES + 1);

    // Distance datapath widths: |d| <= 2^COORD_BITS, three squares summed
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int SQ_W   = 2 * DIFF_W;
    localparam int SXY_W  = SQ_W + 1;
    localparam int SUM_W  = SQ_W + 2;
    localparam int CMP_W  = (SUM_W > EPS_W) ? SUM_W : EPS_W;

    // Distance pipeline depth, entry in to hit out
    localparam int DIST_LAT = 5;
    localparam int DLAT_W   = $clog2(DIST_LAT);

    // Command codes
    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_REMAP = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // Status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_FULL      = 2'd1;
    localparam logic [1:0] STAT_UNWRITTEN = 2'd2;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] z;
    } vtx_t;

    typedef struct packed {
        logic              hit;
        logic [UIDX_W-1:0] idx;
    } hit_t;

endpackage

// ===== rtl/core/vwe_cell.sv =====
module vwe_cell
    import vwe_pkg::*;
(
    input  logic aclk,
    input  logic shift_en,
    input  logic load_en,
    input  vtx_t load_vtx,
    input  vtx_t nbr_vtx,
    output vtx_t vtx
);

    vtx_t vtx_reg;

    // Load a new vertex, or take the neighbor's vertex while the ring turns
    always_ff @(posedge aclk) begin
        if (load_en) begin
            vtx_reg <= load_vtx;
        end else if (shift_en) begin
            vtx_reg <= nbr_vtx;
        end
    end

    assign vtx = vtx_reg;

endmodule

// ===== rtl/core/vwe_dist.sv =====
module vwe_dist
    import vwe_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  logic [UIDX_W-1:0] in_idx,
    input  vtx_t              query,
    input  vtx_t              entry,
    input  logic [EPS_W-1:0]  eps,
    output hit_t              hit
);

    function automatic logic [DIFF_W-1:0] abs_diff(
        input logic [COORD_BITS-1:0] a,
        input logic [COORD_BITS-1:0] b
    );
        logic signed [DIFF_W-1:0] d;
        d = DIFF_W'($signed(a)) - DIFF_W'($signed(b));
        return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    endfunction

    logic              v1_reg, v2_reg, v3_reg, v4_reg;
    logic [UIDX_W-1:0] idx1_reg, idx2_reg, idx3_reg, idx4_reg;
    logic [DIFF_W-1:0] ax1_reg, ay1_reg, az1_reg;
    logic [SQ_W-1:0]   sqx2_reg, sqy2_reg, sqz2_reg;
    logic [SXY_W-1:0]  sxy3_reg;
    logic [SQ_W-1:0]   sz3_reg;
    logic [SUM_W-1:0]  sum4_reg;
    hit_t              hit_reg;

    // Advance the valid and hit flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            hit_reg <= '0;
        end else begin
            v1_reg      <= in_valid;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            v4_reg      <= v3_reg;
            hit_reg.hit <= v4_reg && (CMP_W'(sum4_reg) < CMP_W'(eps));
            hit_reg.idx <= idx4_reg;
        end
    end

    // Per-axis magnitude, square, partial sum, full sum
    always_ff @(posedge aclk) begin
        idx1_reg <= in_idx;
        ax1_reg  <= abs_diff(query.x, entry.x);
        ay1_reg  <= abs_diff(query.y, entry.y);
        az1_reg  <= abs_diff(query.z, entry.z);

        idx2_reg <= idx1_reg;
        sqx2_reg <= ax1_reg * ax1_reg;
        sqy2_reg <= ay1_reg * ay1_reg;
        sqz2_reg <= az1_reg * az1_reg;

        idx3_reg <= idx2_reg;
        sxy3_reg <= SXY_W'(sqx2_reg) + SXY_W'(sqy2_reg);
        sz3_reg  <= sqz2_reg;

        idx4_reg <= idx3_reg;
        sum4_reg <= SUM_W'(sxy3_reg) + SUM_W'(sz3_reg);
    end

    assign hit = hit_reg;

endmodule

// ===== rtl/core/vertex_weld_epsilon.sv =====
// Channel   Direction  Beat contents
// s_        in         cmd, pos_x, pos_y, pos_z, face_index
// m_        out        welded_index, is_new, status
// cfg_      in         eps_squared write data (cfg_data)
//
// An add runs the scan, drain and decide steps, then the response step:
// the ring of vertex cells turns once, one stored vertex per cycle past the
// single distance pipeline. A remap adds a read step; a clear, an unused code,
// an add on a full vertex table or a remap of an unwritten index respond directly.
// Reset clears both counts and sets eps_squared to 1; the vertex cells and the
// remap memory are not cleared. s_ready is high in idle, even while a result
// waits in the output register; a stalled m_ready holds the next result back.
module vertex_weld_epsilon
    import vwe_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_cmd,
    input  logic signed [POS_W-1:0]  s_pos_x,
    input  logic signed [POS_W-1:0]  s_pos_y,
    input  logic signed [POS_W-1:0]  s_pos_z,
    input  logic [FACE_W-1:0]        s_face_index,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [WIDX_W-1:0]        m_welded_index,
    output logic                     m_is_new,
    output logic [1:0]               m_status,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [EPS_W-1:0]         cfg_data
);

    localparam int FI_W = (VCNT_W > FACE_W) ? VCNT_W : FACE_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DECIDE,
        S_READ,
        S_RESP
    } state_t;

    state_t             state_reg;
    logic [EPS_W-1:0]   eps_reg;
    logic [UCNT_W-1:0]  ucnt_reg;
    logic [VCNT_W-1:0]  vcnt_reg;
    vtx_t               query_reg;
    logic [UIDX_W-1:0]  step_reg;
    logic [DLAT_W-1:0]  drain_reg;
    logic               found_reg;
    logic [UIDX_W-1:0]  match_reg;
    logic [WIDX_W-1:0]  res_idx_reg;
    logic               res_new_reg;
    logic [1:0]         res_stat_reg;
    logic               m_valid_reg;
    logic [WIDX_W-1:0]  m_idx_reg;
    logic               m_new_reg;
    logic [1:0]         m_stat_reg;
    logic [UIDX_W-1:0]  rdata_reg;

    logic               shift_en;
    logic               scan_valid;
    logic               ucnt_full;
    logic               insert_en;
    logic               remap_we;
    logic [UIDX_W-1:0]  remap_wdata;
    logic               fi_ok;
    vtx_t               s_vtx;
    hit_t               hit;

    vtx_t               ring [MAX_UNIQUE];
    logic [UIDX_W-1:0]  remap_mem [MAX_VERTICES];

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    // Narrow or widen the coordinates to the stored precision
    assign s_vtx.x = COORD_BITS'($signed(s_pos_x));
    assign s_vtx.y = COORD_BITS'($signed(s_pos_y));
    assign s_vtx.z = COORD_BITS'($signed(s_pos_z));

    assign fi_ok = (FI_W'(s_face_index) < FI_W'(vcnt_reg))
                && (FI_W'(s_face_index) < FI_W'(MAX_VERTICES));

    // Ring control: turn during the scan, load the free cell on a miss with room left
    assign shift_en    = (state_reg == S_SCAN);
    assign scan_valid  = shift_en && (UCNT_W'(step_reg) < ucnt_reg);
    assign ucnt_full   = (ucnt_reg == UCNT_W'(MAX_UNIQUE));
    assign insert_en   = (state_reg == S_DECIDE) && !found_reg && !ucnt_full;
    assign remap_we    = (state_reg == S_DECIDE) && (found_reg || !ucnt_full);
    assign remap_wdata = found_reg ? match_reg : ucnt_reg[UIDX_W-1:0];

    for (genvar i = 0; i < MAX_UNIQUE; i++) begin : g_ring
        vwe_cell u_cell (
            .aclk     (aclk),
            .shift_en (shift_en),
            .load_en  (insert_en && (ucnt_reg[UIDX_W-1:0] == UIDX_W'(i))),
            .load_vtx (query_reg),
            .nbr_vtx  (ring[(i + 1) % MAX_UNIQUE]),
            .vtx      (ring[i])
        );
    end

    vwe_dist u_dist (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (scan_valid),
        .in_idx   (step_reg),
        .query    (query_reg),
        .entry    (ring[0]),
        .eps      (eps_reg),
        .hit      (hit)
    );

    // Remap table: write at the vertex count, read at the incoming face index
    always_ff @(posedge aclk) begin
        if (remap_we) begin
            remap_mem[vcnt_reg[VIDX_W-1:0]] <= remap_wdata;
        end
        rdata_reg <= remap_mem[VIDX_W'(s_face_index)];
    end

    // Sequencer, counts and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            eps_reg     <= EPS_RESET;
            ucnt_reg    <= '0;
            vcnt_reg    <= '0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                eps_reg <= cfg_data;
            end
            // Drop the taken beat unless the response step replaces it
            if (m_ready && (state_reg != S_RESP)) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        query_reg    <= s_vtx;
                        step_reg     <= '0;
                        found_reg    <= 1'b0;
                        res_idx_reg  <= '0;
                        res_new_reg  <= 1'b0;
                        res_stat_reg <= STAT_OK;
                        unique case (s_cmd)
                            CMD_ADD: begin
                                if (vcnt_reg == VCNT_W'(MAX_VERTICES)) begin
                                    res_stat_reg <= STAT_FULL;
                                    state_reg    <= S_RESP;
                                end else begin
                                    state_reg <= S_SCAN;
                                end
                            end
                            CMD_REMAP: begin
                                if (fi_ok) begin
                                    state_reg <= S_READ;
                                end else begin
                                    res_stat_reg <= STAT_UNWRITTEN;
                                    state_reg    <= S_RESP;
                                end
                            end
                            CMD_CLEAR: begin
                                ucnt_reg  <= '0;
                                vcnt_reg  <= '0;
                                state_reg <= S_RESP;
                            end
                            default: begin
                                state_reg <= S_RESP;
                            end
                        endcase
                    end
                end

                S_SCAN: begin
                    if (hit.hit && !found_reg) begin
                        found_reg <= 1'b1;
                        match_reg <= hit.idx;
                    end
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == UIDX_W'(MAX_UNIQUE - 1)) begin
                        drain_reg <= '0;
                        state_reg <= S_DRAIN;
                    end
                end

                S_DRAIN: begin
                    if (hit.hit && !found_reg) begin
                        found_reg <= 1'b1;
                        match_reg <= hit.idx;
                    end
                    drain_reg <= drain_reg + 1'b1;
                    if (drain_reg == DLAT_W'(DIST_LAT - 1)) begin
                        state_reg <= S_DECIDE;
                    end
                end

                S_DECIDE: begin
                    priority if (found_reg) begin
                        res_idx_reg <= WIDX_W'(match_reg);
                        vcnt_reg    <= vcnt_reg + 1'b1;
                    end else if (ucnt_full) begin
                        res_stat_reg <= STAT_FULL;
                    end else begin
                        res_idx_reg <= WIDX_W'(ucnt_reg[UIDX_W-1:0]);
                        res_new_reg <= 1'b1;
                        ucnt_reg    <= ucnt_reg + 1'b1;
                        vcnt_reg    <= vcnt_reg + 1'b1;
                    end
                    state_reg <= S_RESP;
                end

                S_READ: begin
                    res_idx_reg <= WIDX_W'(rdata_reg);
                    state_reg   <= S_RESP;
                end

                S_RESP: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_idx_reg   <= res_idx_reg;
                        m_new_reg   <= res_new_reg;
                        m_stat_reg  <= res_stat_reg;
                        state_reg   <= S_IDLE;
                    end
                end

                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_welded_index = m_idx_reg;
    assign m_is_new       = m_new_reg;
    assign m_status       = m_stat_reg;

    // Unique count never passes the table size
    a_ucnt_max: assert property (@(posedge aclk) disable iff (!aresetn)
        ucnt_reg <= UCNT_W'(MAX_UNIQUE))
        else $error("unique count above table size");

    // Every unique entry was written together with a remap entry
    a_ucnt_vcnt: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(ucnt_reg) <= int'(vcnt_reg))
        else $error("unique count above vertex count");

    // Unique count grows only by one, and only in the decide step
    a_ucnt_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (ucnt_reg > $past(ucnt_reg)) |->
            ($past(state_reg) == S_DECIDE) && (ucnt_reg == $past(ucnt_reg) + 1'b1))
        else $error("unique count changed outside insert");

    // Hits arrive only while a scan is in flight
    a_hit_window: assert property (@(posedge aclk) disable iff (!aresetn)
        hit.hit |-> (state_reg == S_SCAN || state_reg == S_DRAIN))
        else $error("distance hit outside scan");

    // A new entry is always reported with ok status
    a_new_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_is_new) |-> (m_status == STAT_OK))
        else $error("new entry with error status");

endmodule

// ===== sim/weld_checker.sv =====
module weld_checker
    import vwe_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    input  logic                    s_ready,
    input  logic [1:0]              s_cmd,
    input  logic [POS_W-1:0]        s_pos_x,
    input  logic [POS_W-1:0]        s_pos_y,
    input  logic [POS_W-1:0]        s_pos_z,
    input  logic [FACE_W-1:0]       s_face_index,
    input  logic                    m_valid,
    input  logic                    m_ready,
    input  logic [WIDX_W-1:0]       m_welded_index,
    input  logic                    m_is_new,
    input  logic [1:0]              m_status,
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [EPS_W-1:0]        cfg_data,
    output int                      weld_errors,
    output int                      welds_owed
);

    typedef struct packed {
        logic [WIDX_W-1:0] widx;
        logic              is_new;
        logic [1:0]        status;
    } weld_result_t;

    // Shadow copy of the weld tables and the epsilon register
    logic [EPS_W-1:0]  eps_sq;
    logic [POS_W-1:0]  ux [MAX_UNIQUE];
    logic [POS_W-1:0]  uy [MAX_UNIQUE];
    logic [POS_W-1:0]  uz [MAX_UNIQUE];
    int unsigned       remap_tab [MAX_VERTICES];
    int                uniq_count;
    int                vtx_count;

    weld_result_t      pending_welds [$];
    int                err_tally = 0;
    int                beats_seen = 0;

    // Squared difference along one axis; the magnitude fits 25 bits
    function automatic longint unsigned axis_sq(logic [POS_W-1:0] a, logic [POS_W-1:0] b);
        logic [POS_W:0]    d;
        logic [POS_W:0]    m;
        longint unsigned   mag;
        d   = {a[POS_W-1], a} - {b[POS_W-1], b};
        m   = d[POS_W] ? -d : d;
        mag = longint'(m);
        return mag * mag;
    endfunction

    // Apply one command to the shadow tables and return the result it owes
    function automatic weld_result_t weld_outcome(logic [1:0] cmd, logic [POS_W-1:0] x,
                                                  logic [POS_W-1:0] y, logic [POS_W-1:0] z,
                                                  logic [FACE_W-1:0] fi);
        weld_result_t      r;
        int                hit;
        int                j;
        longint unsigned   sq_dist;
        r   = '0;
        hit = -1;
        case (cmd)
            CMD_ADD: begin
                if (vtx_count >= MAX_VERTICES) begin
                    r.status = STAT_FULL;
                end else begin
                    // scan in insertion order, first entry strictly inside wins
                    for (j = 0; j < uniq_count && hit < 0; j++) begin
                        sq_dist = axis_sq(x, ux[j]) + axis_sq(y, uy[j])
                                + axis_sq(z, uz[j]);
                        if (sq_dist < {14'd0, eps_sq})
                            hit = j;
                    end
                    if (hit >= 0) begin
                        remap_tab[vtx_count] = hit;
                        vtx_count++;
                        r.widx = WIDX_W'(hit);
                    end else if (uniq_count >= MAX_UNIQUE) begin
                        r.status = STAT_FULL;
                    end else begin
                        ux[uniq_count] = x;
                        uy[uniq_count] = y;
                        uz[uniq_count] = z;
                        remap_tab[vtx_count] = uniq_count;
                        r.widx   = WIDX_W'(uniq_count);
                        r.is_new = 1'b1;
                        uniq_count++;
                        vtx_count++;
                    end
                end
            end
            CMD_REMAP: begin
                if (int'(fi) < vtx_count)
                    r.widx = WIDX_W'(remap_tab[fi]);
                else
                    r.status = STAT_UNWRITTEN;
            end
            CMD_CLEAR: begin
                uniq_count = 0;
                vtx_count  = 0;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_fault(string msg);
        $display("weld check: result %0d: %s", beats_seen, msg);
        err_tally++;
    endtask

    // Compare result beats, track config writes, predict accepted items
    always @(posedge aclk) begin
        weld_result_t want;
        if (!aresetn) begin
            pending_welds.delete();
            eps_sq     = EPS_RESET;
            uniq_count = 0;
            vtx_count  = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_welds.size() == 0) begin
                    report_fault("result beat with nothing pending");
                end else begin
                    want = pending_welds.pop_front();
                    if (m_welded_index !== want.widx)
                        report_fault($sformatf("welded_index got %0d want %0d",
                                               m_welded_index, want.widx));
                    if (m_is_new !== want.is_new)
                        report_fault($sformatf("is_new got %0b want %0b",
                                               m_is_new, want.is_new));
                    if (m_status !== want.status)
                        report_fault($sformatf("status got %0d want %0d",
                                               m_status, want.status));
                end
                beats_seen++;
            end
            if (cfg_valid && cfg_ready)
                eps_sq = cfg_data;
            if (s_valid && s_ready)
                pending_welds.insert(pending_welds.size(),
                                     weld_outcome(s_cmd, s_pos_x, s_pos_y, s_pos_z,
                                                  s_face_index));
        end
        welds_owed  <= pending_welds.size();
        weld_errors <= err_tally;
    end

endmodule

// ===== sim/tb.sv =====
module tb;
    import vwe_pkg::*;

    localparam int unsigned CLK_PERIOD   = 12;
    localparam int unsigned LIMIT_CYCLES = 2_000_000;
    localparam logic [1:0]  CMD_UNUSED   = 2'd3;
    localparam logic [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
    localparam logic [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic [EPS_W-1:0] EPS_MAX = {EPS_W{1'b1}};

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [1:0]            s_cmd = CMD_CLEAR;
    logic [POS_W-1:0]      s_pos_x = '0;
    logic [POS_W-1:0]      s_pos_y = '0;
    logic [POS_W-1:0]      s_pos_z = '0;
    logic [FACE_W-1:0]     s_face_index = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b1;
    logic [WIDX_W-1:0]     m_welded_index;
    logic                  m_is_new;
    logic [1:0]            m_status;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [EPS_W-1:0]      cfg_data = '0;

    int                    weld_errors;
    int                    welds_owed;
    bit                    calm = 1'b0;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    vertex_weld_epsilon i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_pos_x        (s_pos_x),
        .s_pos_y        (s_pos_y),
        .s_pos_z        (s_pos_z),
        .s_face_index   (s_face_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_welded_index (m_welded_index),
        .m_is_new       (m_is_new),
        .m_status       (m_status),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    weld_checker i_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_pos_x        (s_pos_x),
        .s_pos_y        (s_pos_y),
        .s_pos_z        (s_pos_z),
        .s_face_index   (s_face_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_welded_index (m_welded_index),
        .m_is_new       (m_is_new),
        .m_status       (m_status),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .weld_errors    (weld_errors),
        .welds_owed     (welds_owed)
    );

    // Stall the result channel in bursts, never once the run calms down
    initial begin
        forever begin
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 60)) @(posedge aclk);
            if (!calm) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
            end
        end
    end

    function automatic logic [POS_W-1:0] any_pos();
        return POS_W'($urandom);
    endfunction

    function automatic vtx_t any_vtx();
        vtx_t p;
        p.x = any_pos();
        p.y = any_pos();
        p.z = any_pos();
        return p;
    endfunction

    // Offset a coordinate by a random amount within +-amp
    function automatic logic [POS_W-1:0] nudge(logic [POS_W-1:0] c, int unsigned amp);
        int off;
        off = int'($urandom_range(0, 2 * amp)) - int'(amp);
        return c + POS_W'(off);
    endfunction

    // Present one beat, optionally after a gap, and hold it until accepted
    task automatic push_item(logic [1:0] cmd, logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                             logic [POS_W-1:0] z, logic [FACE_W-1:0] fi);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_cmd        <= cmd;
        s_pos_x      <= x;
        s_pos_y      <= y;
        s_pos_z      <= z;
        s_face_index <= fi;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic add_at(vtx_t p);
        push_item(CMD_ADD, p.x, p.y, p.z, FACE_W'($urandom));
    endtask

    task automatic add_near(vtx_t p, int unsigned amp);
        push_item(CMD_ADD, nudge(p.x, amp), nudge(p.y, amp), nudge(p.z, amp),
                  FACE_W'($urandom));
    endtask

    task automatic send_cmd(logic [1:0] cmd, logic [FACE_W-1:0] fi);
        push_item(cmd, any_pos(), any_pos(), any_pos(), fi);
    endtask

    // Hold the sender until every pending result has come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (welds_owed != 0);
    endtask

    task automatic write_eps(logic [EPS_W-1:0] v);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        vtx_t             p;
        vtx_t             centers [$];
        vtx_t             stored [$];
        logic [EPS_W-1:0] eps_plan [4];
        int               vtx_sent;
        int               near_ok;
        int               r;
        int unsigned      amp;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset epsilon of one, exact match only
        send_cmd(CMD_REMAP, FACE_W'(0));
        add_at('{POS_MIN, POS_MIN, POS_MIN});
        add_at('{POS_MAX, POS_MAX, POS_MAX});
        add_at('{POS_MIN, POS_MIN, POS_MIN});
        // distance of exactly epsilon must not merge
        add_at('{POS_MIN + 1'b1, POS_MIN, POS_MIN});
        add_at('{'0, '0, '0});
        for (int i = 0; i < 6; i++)
            send_cmd(CMD_REMAP, FACE_W'(i));
        send_cmd(CMD_REMAP, {FACE_W{1'b1}});
        send_cmd(CMD_UNUSED, {FACE_W{1'b1}});
        send_cmd(CMD_CLEAR, FACE_W'(0));
        send_cmd(CMD_REMAP, FACE_W'(0));

        // Zero epsilon never merges, full epsilon merges everything
        write_eps('0);
        add_at('{'0, '0, '0});
        add_at('{'0, '0, '0});
        write_eps(EPS_MAX);
        add_at('{POS_MAX, POS_MAX, POS_MAX});
        add_at('{POS_MIN, POS_MIN, POS_MIN});
        send_cmd(CMD_REMAP, FACE_W'(2));
        send_cmd(CMD_CLEAR, FACE_W'(0));

        // Clustered sessions under a few epsilon settings
        eps_plan[0] = EPS_W'(1) << 28;
        eps_plan[1] = EPS_W'(1);
        eps_plan[2] = EPS_W'({$urandom, $urandom});
        eps_plan[3] = EPS_W'(1) << 32;
        vtx_sent = 0;
        for (int blk = 0; blk < 4; blk++) begin
            write_eps(eps_plan[blk]);
            for (int n = 0; n < 75; n++) begin
                r = $urandom_range(0, 99);
                if (r < 3) begin
                    send_cmd(CMD_CLEAR, FACE_W'($urandom));
                    centers.delete();
                    vtx_sent = 0;
                end else if (r < 5) begin
                    send_cmd(CMD_UNUSED, FACE_W'($urandom));
                end else if (r < 8) begin
                    send_cmd(CMD_REMAP, FACE_W'($urandom));
                end else if (r < 20) begin
                    send_cmd(CMD_REMAP, FACE_W'($urandom_range(0,
                             (vtx_sent + 3 > 1023) ? 1023 : vtx_sent + 3)));
                end else if (r < 28 || centers.size() == 0) begin
                    p = any_vtx();
                    if (centers.size() < 12)
                        centers.insert(centers.size(), p);
                    add_at(p);
                    vtx_sent++;
                end else begin
                    amp = ($urandom_range(0, 3) == 0) ? 0 : (1 << $urandom_range(8, 15));
                    add_near(centers[$urandom_range(0, centers.size() - 1)], amp);
                    vtx_sent++;
                end
            end
        end

        // Fill the unique table past its end with zero epsilon
        write_eps('0);
        send_cmd(CMD_CLEAR, FACE_W'(0));
        for (int n = 0; n < MAX_UNIQUE + 6; n++) begin
            p = any_vtx();
            stored.insert(stored.size(), p);
            add_at(p);
            if (n % 16 == 15)
                send_cmd(CMD_REMAP, FACE_W'($urandom));
        end

        // Weld onto the full unique table until the vertex table overflows
        write_eps(EPS_W'(1) << 30);
        near_ok = 0;
        while (near_ok < MAX_VERTICES - MAX_UNIQUE + 24) begin
            calm = (near_ok >= 700);
            r = $urandom_range(0, 99);
            if (r < 6) begin
                send_cmd(CMD_REMAP, FACE_W'($urandom));
            end else if (r < 8) begin
                add_at(any_vtx());
            end else if (r < 9) begin
                send_cmd(CMD_UNUSED, FACE_W'($urandom));
            end else begin
                add_near(stored[$urandom_range(0, MAX_UNIQUE - 1)], 1 << 13);
                near_ok++;
            end
        end
        send_cmd(CMD_REMAP, {FACE_W{1'b1}});

        wait_drained();
        repeat (300) @(posedge aclk);
        if (weld_errors == 0 && welds_owed == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    // Give up on a hung run
    initial begin
        #(CLK_PERIOD * LIMIT_CYCLES);
        $display("tb NOT OK");
        $finish;
    end

endmodule

// ===== vertex_weld_epsilon.f =====
rtl/core/vwe_pkg.sv
rtl/core/vwe_cell.sv
rtl/core/vwe_dist.sv
rtl/core/vertex_weld_epsilon.sv
sim/weld_checker.sv
sim/tb.sv
